@@ rtl/breakpoint_match_table_core_macros.svh @@
// Assertion macros shared by the breakpoint match table RTL.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef BREAKPOINT_MATCH_TABLE_CORE_MACROS_SVH
`define BREAKPOINT_MATCH_TABLE_CORE_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define BMT_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define BMT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/bmt_pkg.sv @@
// Shared types, codes and helper functions of the breakpoint match table.
// No dependencies; used by every RTL module of the block.
`default_nettype none

package bmt_pkg;

  localparam int unsigned ENTRIES_DEF = 16;

  typedef enum logic [2:0] {
    CMD_ADD     = 3'd0,
    CMD_CLR_ID  = 3'd1,
    CMD_CLR_SRC = 3'd2,
    CMD_SET_ARM = 3'd3,
    CMD_SNAP_EN = 3'd4,
    CMD_MATCH   = 3'd5
  } cmd_e;

  localparam logic [1:0] SRC_TEMP = 2'd0;
  localparam logic [1:0] SRC_SNAP = 2'd1;
  localparam logic [1:0] KIND_RAM = 2'd1;
  localparam logic [1:0] KIND_ROM = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_APPEND,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    PH_DUP,
    PH_ALLOC,
    PH_FIND,
    PH_SHIFT,
    PH_SWEEP,
    PH_MATCH
  } phase_e;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] address;
    logic [15:0] bank;
    logic [1:0]  kind;
    logic [1:0]  source;
    logic        armed;
  } entry_t;

  typedef struct packed {
    logic rd;
    logic wr;
  } mem_ctl_t;

  // Next breakpoint id: increment, wrapping past zero to one.
  function automatic logic [15:0] next_id(input logic [15:0] cur);
    logic [15:0] n;
    n = cur + 16'd1;
    if (n == 16'd0) begin
      n = 16'd1;
    end
    return n;
  endfunction

  function automatic logic bank_hit(input logic [1:0] kind, input logic [15:0] bank,
                                    input logic [15:0] ram, input logic [15:0] rom);
    logic h;
    case (kind)
      KIND_RAM: h = (ram == bank);
      KIND_ROM: h = (rom == bank);
      default:  h = 1'b1;
    endcase
    return h;
  endfunction

endpackage

`default_nettype wire

@@ rtl/bmt_mem.sv @@
// Entry storage of the breakpoint match table: one write port, one read
// port with registered read data. Depends on bmt_pkg.
`default_nettype none

module bmt_mem #(
  parameter int unsigned ENTRIES = bmt_pkg::ENTRIES_DEF
) (
  input  wire logic                                          clk_i,
  input  wire bmt_pkg::mem_ctl_t                             ctl_i,
  input  wire logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] rd_addr_i,
  input  wire logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] wr_addr_i,
  input  wire bmt_pkg::entry_t                               wr_data_i,
  output bmt_pkg::entry_t                                    rd_data_o
);
  import bmt_pkg::*;

  entry_t mem [ENTRIES];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

@@ rtl/bmt_seq.sv @@
// Command sequencer of the breakpoint match table: scans the entry memory
// one entry per read, rewrites entries, allocates ids. Depends on bmt_pkg.
`default_nettype none

module bmt_seq #(
  parameter int unsigned ENTRIES = bmt_pkg::ENTRIES_DEF
) (
  input  wire logic                                          clk_i,
  input  wire logic                                          rst_ni,
  input  wire logic                                          in_valid_i,
  output logic                                               in_stall_o,
  input  wire logic [2:0]                                    cmd_i,
  input  wire logic [15:0]                                   address_i,
  input  wire logic [1:0]                                    kind_i,
  input  wire logic [15:0]                                   bank_i,
  input  wire logic [1:0]                                    source_i,
  input  wire logic [15:0]                                   ident_i,
  input  wire logic                                          flag_i,
  input  wire logic [15:0]                                   visible_ram_bank_i,
  input  wire logic [15:0]                                   visible_rom_bank_i,
  input  wire logic                                          out_free_i,
  output logic                                               done_o,
  output logic [15:0]                                        result_o,
  output logic [$clog2(ENTRIES + 1)-1:0]                     count_o,
  output bmt_pkg::mem_ctl_t                                  mem_ctl_o,
  output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0]      rd_addr_o,
  output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0]      wr_addr_o,
  output bmt_pkg::entry_t                                    wr_data_o,
  input  wire bmt_pkg::entry_t                               rd_data_i
);
  import bmt_pkg::*;
  `include "breakpoint_match_table_core_macros.svh"

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] FULL = CW'(ENTRIES);

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic [CW-1:0] idx_q, idx_d, wr_q, wr_d, count_q, count_d;
  logic [15:0] last_id_q, last_id_d, cand_q, cand_d, result_q, result_d;
  logic snap_q, snap_d;

  cmd_e        cmd_q, cmd_d;
  logic [15:0] addr_q, addr_d, bank_q, bank_d, ident_q, ident_d;
  logic [15:0] ram_q, ram_d, rom_q, rom_d;
  logic [1:0]  kind_q, kind_d, src_q, src_d;
  logic        flag_q, flag_d;

  logic   at_end, full, arm, dup_hit, id_hit, match_hit, cand_used;
  entry_t e;

  assign e         = rd_data_i;
  assign at_end    = (idx_q == count_q);
  assign full      = (count_q == FULL);
  assign arm       = (src_q != SRC_SNAP) || snap_q;
  assign dup_hit   = (e.source == src_q) && (e.address == addr_q) &&
                     (e.kind == kind_q) && (e.bank == bank_q);
  assign id_hit    = (e.id == ident_q);
  assign cand_used = (e.id == cand_q);
  assign match_hit = (e.id != ident_q) && e.armed && (e.address == addr_q) &&
                     bank_hit(e.kind, e.bank, ram_q, rom_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (cmd_i)
            CMD_ADD:     state_d = (source_i == SRC_TEMP && full) ? ST_DONE : ST_READ;
            CMD_CLR_ID,
            CMD_SET_ARM: state_d = (ident_i == 16'd0) ? ST_DONE : ST_READ;
            CMD_CLR_SRC,
            CMD_SNAP_EN,
            CMD_MATCH:   state_d = ST_READ;
            default:     state_d = ST_DONE;
          endcase
        end
      end
      ST_READ: begin
        if (!at_end) begin
          state_d = ST_EVAL;
        end else begin
          case (phase_q)
            PH_DUP:   state_d = full ? ST_DONE : ST_READ;
            PH_ALLOC: state_d = ST_APPEND;
            default:  state_d = ST_DONE;
          endcase
        end
      end
      ST_EVAL: begin
        case (phase_q)
          PH_DUP:   state_d = dup_hit ? ST_DONE : ST_READ;
          PH_FIND:  state_d = (id_hit && cmd_q == CMD_SET_ARM) ? ST_DONE : ST_READ;
          PH_MATCH: state_d = match_hit ? ST_DONE : ST_READ;
          default:  state_d = ST_READ;
        endcase
      end
      ST_APPEND: state_d = ST_DONE;
      ST_DONE:   state_d = out_free_i ? ST_IDLE : ST_DONE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath.
  always_comb begin
    phase_d   = phase_q;
    idx_d     = idx_q;
    wr_d      = wr_q;
    count_d   = count_q;
    last_id_d = last_id_q;
    cand_d    = cand_q;
    result_d  = result_q;
    snap_d    = snap_q;
    cmd_d     = cmd_q;
    addr_d    = addr_q;
    bank_d    = bank_q;
    ident_d   = ident_q;
    ram_d     = ram_q;
    rom_d     = rom_q;
    kind_d    = kind_q;
    src_d     = src_q;
    flag_d    = flag_q;
    mem_ctl_o = '0;
    rd_addr_o = idx_q[IW-1:0];
    wr_addr_o = idx_q[IW-1:0];
    wr_data_o = e;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d    = cmd_e'(cmd_i);
          addr_d   = address_i;
          bank_d   = bank_i;
          ident_d  = ident_i;
          ram_d    = visible_ram_bank_i;
          rom_d    = visible_rom_bank_i;
          kind_d   = kind_i;
          src_d    = source_i;
          flag_d   = flag_i;
          idx_d    = '0;
          wr_d     = '0;
          result_d = '0;
          cand_d   = next_id(last_id_q);
          case (cmd_i)
            CMD_ADD:     phase_d = (source_i == SRC_TEMP) ? PH_ALLOC : PH_DUP;
            CMD_CLR_ID,
            CMD_SET_ARM: phase_d = PH_FIND;
            CMD_CLR_SRC: phase_d = PH_SWEEP;
            CMD_SNAP_EN: begin
              phase_d = PH_SWEEP;
              snap_d  = flag_i;
            end
            default:     phase_d = PH_MATCH;
          endcase
        end
      end
      ST_READ: begin
        if (!at_end) begin
          mem_ctl_o.rd = 1'b1;
        end else begin
          case (phase_q)
            PH_DUP: begin
              phase_d = PH_ALLOC;
              idx_d   = '0;
            end
            PH_SHIFT: begin
              count_d  = count_q - CW'(1);
              result_d = ident_q;
            end
            PH_SWEEP: begin
              if (cmd_q == CMD_CLR_SRC) begin
                count_d = wr_q;
              end
            end
            default: ;
          endcase
        end
      end
      ST_EVAL: begin
        idx_d = idx_q + CW'(1);
        case (phase_q)
          PH_DUP: begin
            if (dup_hit) begin
              mem_ctl_o.wr    = 1'b1;
              wr_data_o.armed = arm;
              result_d        = e.id;
            end
          end
          PH_ALLOC: begin
            // A taken candidate restarts the scan with the following id.
            if (cand_used) begin
              cand_d = next_id(cand_q);
              idx_d  = '0;
            end
          end
          PH_FIND: begin
            if (id_hit) begin
              if (cmd_q == CMD_SET_ARM) begin
                mem_ctl_o.wr    = 1'b1;
                wr_data_o.armed = flag_q;
                result_d        = ident_q;
              end else begin
                phase_d = PH_SHIFT;
              end
            end
          end
          PH_SHIFT: begin
            mem_ctl_o.wr = 1'b1;
            wr_addr_o    = idx_q[IW-1:0] - IW'(1);
          end
          PH_SWEEP: begin
            if (cmd_q == CMD_CLR_SRC) begin
              if (e.source != src_q) begin
                mem_ctl_o.wr = 1'b1;
                wr_addr_o    = wr_q[IW-1:0];
                wr_d         = wr_q + CW'(1);
              end
            end else if (e.source == SRC_SNAP) begin
              mem_ctl_o.wr    = 1'b1;
              wr_data_o.armed = flag_q;
            end
          end
          PH_MATCH: begin
            if (match_hit) begin
              result_d = e.id;
            end
          end
          default: ;
        endcase
      end
      ST_APPEND: begin
        mem_ctl_o.wr = 1'b1;
        wr_addr_o    = count_q[IW-1:0];
        wr_data_o    = '{id: cand_q, address: addr_q, bank: bank_q, kind: kind_q,
                         source: src_q, armed: arm};
        count_d      = count_q + CW'(1);
        last_id_d    = cand_q;
        result_d     = cand_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      phase_q   <= PH_MATCH;
      idx_q     <= '0;
      wr_q      <= '0;
      count_q   <= '0;
      last_id_q <= '0;
      snap_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      idx_q     <= idx_d;
      wr_q      <= wr_d;
      count_q   <= count_d;
      last_id_q <= last_id_d;
      snap_q    <= snap_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q   <= cand_d;
    result_q <= result_d;
    cmd_q    <= cmd_d;
    addr_q   <= addr_d;
    bank_q   <= bank_d;
    ident_q  <= ident_d;
    ram_q    <= ram_d;
    rom_q    <= rom_d;
    kind_q   <= kind_d;
    src_q    <= src_d;
    flag_q   <= flag_d;
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign done_o     = (state_q == ST_DONE);
  assign result_o   = result_q;
  assign count_o    = count_q;

  `BMT_ASSERT_ALWAYS(a_count_range, count_q <= FULL, "entry count above table size")
  `BMT_ASSERT_ALWAYS(a_one_port_op, !(mem_ctl_o.rd && mem_ctl_o.wr), "read and write together")
  `BMT_ASSERT_NEXT(a_read_eval, mem_ctl_o.rd, state_q == ST_EVAL, "read not followed by eval")
  `BMT_ASSERT_NEXT(a_append_cnt, state_q == ST_APPEND, count_q == $past(count_q) + CW'(1),
                   "append did not grow the table")

endmodule

`default_nettype wire

@@ rtl/breakpoint_match_table_core.sv @@
// Breakpoint match table, top level: entry memory, command sequencer and
// the result word register. A command is started, each entry is read from
// the entry memory and then evaluated or written back, an add appends its
// entry, and the result is handed over. Match, set armed and clear stop at
// the hit; clear by id then moves the later entries up; clear by source and
// snapshot enable read every entry. Add scans for a duplicate (other than
// temporary source), stopping at a hit, and then reads the entries once more
// for each id candidate tried. A new word is taken only while the sequencer
// is idle; a finished result word waits in the output register while the
// next command is worked on.
`default_nettype none

module breakpoint_match_table_core #(
  parameter int unsigned ENTRIES = bmt_pkg::ENTRIES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  cmd_i,
  input  wire logic [15:0] address_i,
  input  wire logic [1:0]  kind_i,
  input  wire logic [15:0] bank_i,
  input  wire logic [1:0]  source_i,
  input  wire logic [15:0] ident_i,
  input  wire logic        flag_i,
  input  wire logic [15:0] visible_ram_bank_i,
  input  wire logic [15:0] visible_rom_bank_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      result_id_o,
  output logic [4:0]       entry_total_o
);
  import bmt_pkg::*;

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  mem_ctl_t      mem_ctl;
  logic [IW-1:0] rd_addr, wr_addr;
  entry_t        wr_data, rd_data;
  logic          done, out_free;
  logic [15:0]   seq_result;
  logic [CW-1:0] seq_count;
  logic [CW+4:0] count_ext;

  logic        out_valid_q;
  logic [15:0] result_q;
  logic [4:0]  total_q;

  bmt_mem #(.ENTRIES(ENTRIES)) u_mem (
    .clk_i     (clk_i),
    .ctl_i     (mem_ctl),
    .rd_addr_i (rd_addr),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data)
  );

  bmt_seq #(.ENTRIES(ENTRIES)) u_seq (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .cmd_i              (cmd_i),
    .address_i          (address_i),
    .kind_i             (kind_i),
    .bank_i             (bank_i),
    .source_i           (source_i),
    .ident_i            (ident_i),
    .flag_i             (flag_i),
    .visible_ram_bank_i (visible_ram_bank_i),
    .visible_rom_bank_i (visible_rom_bank_i),
    .out_free_i         (out_free),
    .done_o             (done),
    .result_o           (seq_result),
    .count_o            (seq_count),
    .mem_ctl_o          (mem_ctl),
    .rd_addr_o          (rd_addr),
    .wr_addr_o          (wr_addr),
    .wr_data_o          (wr_data),
    .rd_data_i          (rd_data)
  );

  // The output register may be reloaded in the cycle its word is taken.
  assign out_free  = !out_valid_q || !out_stall_i;
  assign count_ext = {5'd0, seq_count};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && done) begin
      result_q <= seq_result;
      total_q  <= count_ext[4:0];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_id_o   = result_q;
  assign entry_total_o = total_q;

endmodule

`default_nettype wire

@@ test/breakpoint_match_table_core_tb.sv @@
// Self-checking testbench for breakpoint_match_table_core: a table predictor, a
// randomized driver and a checking monitor on the valid/stall channels.
// Depends on bmt_pkg and the breakpoint_match_table_core RTL only.
`timescale 1ns / 1ps

module breakpoint_match_table_core_tb;
  import bmt_pkg::*;

  localparam int SLOTS = 16;
  localparam int RANDOM_WORDS = 1030;
  localparam int QUIET_TAIL = 150;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 700;
  localparam int HOLD_AT = 250;
  localparam int HOLD_CYCLES = 400;

  localparam logic [2:0] CMD_RSVD_A = 3'd6;
  localparam logic [2:0] CMD_RSVD_B = 3'd7;
  localparam logic [1:0] KIND_ANY = 2'd0;
  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam logic [1:0] SRC_OTHER_A = 2'd2;
  localparam logic [1:0] SRC_OTHER_B = 2'd3;

  typedef struct {
    logic [2:0]  cmd;
    logic [15:0] addr;
    logic [1:0]  kind;
    logic [15:0] bank;
    logic [1:0]  src;
    logic [15:0] ident;
    logic        flag;
    logic [15:0] ram;
    logic [15:0] rom;
    logic [15:0] res;
    logic [4:0]  total;
  } word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  cmd = '0;
  logic [15:0] address = '0;
  logic [1:0]  kind = '0;
  logic [15:0] bank = '0;
  logic [1:0]  source = '0;
  logic [15:0] ident = '0;
  logic        flag = 1'b0;
  logic [15:0] ram_bank = '0;
  logic [15:0] rom_bank = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] result_id;
  logic [4:0]  entry_total;

  // Predicted table contents.
  logic [15:0] bp_id[SLOTS];
  logic [15:0] bp_addr[SLOTS];
  logic [15:0] bp_bank[SLOTS];
  logic [1:0]  bp_kind[SLOTS];
  logic [1:0]  bp_src[SLOTS];
  logic        bp_armed[SLOTS];
  int          bp_count = 0;
  logic [15:0] bp_last_id = '0;
  logic        bp_snap_en = 1'b0;

  word_t pend_q[$];
  word_t result_q[$];
  word_t cur;
  int errors = 0;
  int words_sent = 0;
  int results_seen = 0;
  int total_words = 0;
  int gap = 0;
  int stall_burst = 0;
  int hold_left = 0;
  bit held = 0;
  int idle_cycles = 0;

  always #10 clk_i = ~clk_i;

  breakpoint_match_table_core u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .cmd_i(cmd), .address_i(address), .kind_i(kind), .bank_i(bank),
    .source_i(source), .ident_i(ident), .flag_i(flag),
    .visible_ram_bank_i(ram_bank), .visible_rom_bank_i(rom_bank),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .result_id_o(result_id), .entry_total_o(entry_total)
  );

  function automatic int slot_of(logic [15:0] id);
    if (id == 16'd0) return -1;
    for (int i = 0; i < bp_count; i++) begin
      if (bp_id[i] == id) return i;
    end
    return -1;
  endfunction

  task automatic move_slot(int dst, int src_pos);
    bp_id[dst] = bp_id[src_pos];
    bp_addr[dst] = bp_addr[src_pos];
    bp_bank[dst] = bp_bank[src_pos];
    bp_kind[dst] = bp_kind[src_pos];
    bp_src[dst] = bp_src[src_pos];
    bp_armed[dst] = bp_armed[src_pos];
  endtask

  // Applies one command word to the predicted table and fills in its result.
  task automatic table_update(inout word_t w);
    int pos;
    int keep;
    logic arm;
    logic done;
    logic [15:0] next;
    w.res = '0;
    case (w.cmd)
      CMD_ADD: begin
        arm = (w.src != SRC_SNAP) || bp_snap_en;
        done = 1'b0;
        if (w.src != SRC_TEMP) begin
          for (int i = 0; i < bp_count && !done; i++) begin
            if (bp_src[i] == w.src && bp_addr[i] == w.addr && bp_kind[i] == w.kind &&
                bp_bank[i] == w.bank) begin
              bp_armed[i] = arm;
              w.res = bp_id[i];
              done = 1'b1;
            end
          end
        end
        if (!done && bp_count < SLOTS) begin
          next = bp_last_id;
          for (int i = 0; i <= bp_count; i++) begin
            next = next + 16'd1;
            if (next == 16'd0) next = 16'd1;
            if (slot_of(next) < 0) break;
          end
          bp_last_id = next;
          bp_id[bp_count] = next;
          bp_addr[bp_count] = w.addr;
          bp_bank[bp_count] = w.bank;
          bp_kind[bp_count] = w.kind;
          bp_src[bp_count] = w.src;
          bp_armed[bp_count] = arm;
          bp_count++;
          w.res = next;
        end
      end
      CMD_CLR_ID: begin
        pos = slot_of(w.ident);
        if (pos >= 0) begin
          for (int i = pos; i + 1 < bp_count; i++) move_slot(i, i + 1);
          bp_count--;
          w.res = w.ident;
        end
      end
      CMD_CLR_SRC: begin
        keep = 0;
        for (int i = 0; i < bp_count; i++) begin
          if (bp_src[i] != w.src) begin
            move_slot(keep, i);
            keep++;
          end
        end
        bp_count = keep;
      end
      CMD_SET_ARM: begin
        pos = slot_of(w.ident);
        if (pos >= 0) begin
          bp_armed[pos] = w.flag;
          w.res = w.ident;
        end
      end
      CMD_SNAP_EN: begin
        bp_snap_en = w.flag;
        for (int i = 0; i < bp_count; i++) begin
          if (bp_src[i] == SRC_SNAP) bp_armed[i] = w.flag;
        end
      end
      CMD_MATCH: begin
        for (int i = 0; i < bp_count; i++) begin
          if (bp_id[i] != w.ident && bp_armed[i] && bp_addr[i] == w.addr &&
              (bp_kind[i] == KIND_RAM ? w.ram == bp_bank[i] :
               bp_kind[i] == KIND_ROM ? w.rom == bp_bank[i] : 1'b1)) begin
            w.res = bp_id[i];
            break;
          end
        end
      end
      default: ;
    endcase
    w.total = bp_count[4:0];
  endtask

  function automatic word_t mk(logic [2:0] c, logic [15:0] a, logic [1:0] k, logic [15:0] b,
                               logic [1:0] s, logic [15:0] id, logic f, logic [15:0] ra,
                               logic [15:0] ro);
    word_t w;
    w.cmd = c; w.addr = a; w.kind = k; w.bank = b; w.src = s;
    w.ident = id; w.flag = f; w.ram = ra; w.rom = ro;
    w.res = '0; w.total = '0;
    return w;
  endfunction

  task automatic queue_word(word_t w);
    table_update(w);
    pend_q.push_back(w);
    total_words++;
  endtask

  // Small pools keep duplicates and probe hits frequent.
  function automatic logic [15:0] pick_value();
    logic [15:0] pool[4] = '{16'h0000, 16'hFFFF, 16'h8000, 16'h1234};
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return pool[$urandom_range(0, 3)];
  endfunction

  function automatic logic [15:0] pick_ident();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12 && bp_count > 0) return bp_id[$urandom_range(0, bp_count - 1)];
    if (r < 15) return 16'd0;
    return 16'($urandom);
  endfunction

  task automatic random_word(int mix);
    word_t w;
    int r;
    int pick;
    w = mk(CMD_ADD, pick_value(), 2'($urandom_range(0, 3)), pick_value(),
           2'($urandom_range(0, 3)), pick_ident(), 1'($urandom), pick_value(),
           pick_value());
    // Half the probes aim at a stored entry, with its bank visible half the time.
    if (bp_count > 0 && $urandom_range(0, 1)) begin
      pick = $urandom_range(0, bp_count - 1);
      w.addr = bp_addr[pick];
      if ($urandom_range(0, 1)) begin
        w.ram = bp_bank[pick];
        w.rom = bp_bank[pick];
      end
    end
    r = $urandom_range(0, 99);
    case (mix)
      0: w.cmd = r < 60 ? CMD_ADD : r < 90 ? CMD_MATCH : CMD_SET_ARM;
      1: w.cmd = r < 25 ? CMD_ADD : r < 35 ? CMD_CLR_ID : r < 40 ? CMD_CLR_SRC :
                 r < 50 ? CMD_SET_ARM : r < 56 ? CMD_SNAP_EN : r < 97 ? CMD_MATCH :
                 r < 98 ? CMD_RSVD_A : CMD_RSVD_B;
      default: w.cmd = r < 15 ? CMD_ADD : r < 50 ? CMD_CLR_ID : r < 60 ? CMD_CLR_SRC :
                       r < 70 ? CMD_SNAP_EN : CMD_MATCH;
    endcase
    queue_word(w);
  endtask

  // Driver: a new word is presented once the previous one has been taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        result_q.push_back(cur);
        words_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (gap > 0) begin
          gap <= gap - 1;
          in_valid <= 1'b0;
        end else if (pend_q.size() > 0) begin
          cur = pend_q.pop_front();
          cmd <= cur.cmd;
          address <= cur.addr;
          kind <= cur.kind;
          bank <= cur.bank;
          source <= cur.src;
          ident <= cur.ident;
          flag <= cur.flag;
          ram_bank <= cur.ram;
          rom_bank <= cur.rom;
          in_valid <= 1'b1;
          if (words_sent < total_words - QUIET_TAIL && $urandom_range(0, 4) == 0) begin
            gap <= $urandom_range(1, 17);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result word and drives the receiver's stall.
  always @(posedge clk_i or negedge rst_ni) begin
    word_t e;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (result_q.size() == 0) begin
          $error("unexpected result word: result_id %0h entry_total %0d", result_id,
                 entry_total);
          errors++;
        end else begin
          e = result_q.pop_front();
          if (result_id !== e.res) begin
            $error("result_id: expected %0h, got %0h", e.res, result_id);
            errors++;
          end
          if (entry_total !== e.total) begin
            $error("entry_total: expected %0d, got %0d", e.total, entry_total);
            errors++;
          end
        end
        // One long hold lets the block back up into its input.
        if (results_seen == HOLD_AT && !held) begin
          held = 1;
          hold_left = HOLD_CYCLES;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_burst > 0) begin
        stall_burst--;
        out_stall <= 1'b1;
      end else if (results_seen < total_words - QUIET_TAIL && $urandom_range(0, 5) == 0) begin
        stall_burst = $urandom_range(0, 16);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("breakpoint_match_table_core_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    queue_word(mk(CMD_ADD, 16'h0000, KIND_ANY, 16'h0000, SRC_TEMP, 0, 0, 0, 0));
    queue_word(mk(CMD_ADD, 16'hFFFF, KIND_RAM, 16'hFFFF, SRC_OTHER_A, 0, 1, 0, 0));
    queue_word(mk(CMD_ADD, 16'hFFFF, KIND_RAM, 16'hFFFF, SRC_OTHER_A, 0, 1, 0, 0));
    queue_word(mk(CMD_ADD, 16'h0000, KIND_ANY, 16'h0000, SRC_TEMP, 0, 0, 0, 0));
    queue_word(mk(CMD_ADD, 16'h8000, KIND_ROM, 16'h0001, SRC_SNAP, 0, 0, 0, 0));
    queue_word(mk(CMD_ADD, 16'h1234, KIND_SPARE, 16'h7FFF, SRC_OTHER_B, 0, 0, 0, 0));
    queue_word(mk(CMD_MATCH, 16'h8000, KIND_ANY, 0, SRC_TEMP, 0, 0, 0, 16'h0001));
    queue_word(mk(CMD_SNAP_EN, 0, KIND_ANY, 0, SRC_TEMP, 0, 1, 0, 0));
    queue_word(mk(CMD_MATCH, 16'h8000, KIND_ANY, 0, SRC_TEMP, 0, 0, 0, 16'h0001));
    queue_word(mk(CMD_MATCH, 16'hFFFF, KIND_ANY, 0, SRC_TEMP, 16'd2, 0, 16'hFFFF, 0));
    queue_word(mk(CMD_MATCH, 16'hFFFF, KIND_ANY, 0, SRC_TEMP, 16'd0, 0, 16'hFFFF, 0));
    queue_word(mk(CMD_MATCH, 16'h1234, KIND_ANY, 0, SRC_TEMP, 0, 0, 16'h1111, 16'h2222));
    queue_word(mk(CMD_SET_ARM, 0, KIND_ANY, 0, SRC_TEMP, 16'd2, 0, 0, 0));
    queue_word(mk(CMD_MATCH, 16'hFFFF, KIND_ANY, 0, SRC_TEMP, 0, 0, 16'hFFFF, 0));
    queue_word(mk(CMD_SET_ARM, 0, KIND_ANY, 0, SRC_TEMP, 16'd0, 1, 0, 0));
    queue_word(mk(CMD_CLR_ID, 0, KIND_ANY, 0, SRC_TEMP, 16'd0, 0, 0, 0));
    queue_word(mk(CMD_CLR_ID, 0, KIND_ANY, 0, SRC_TEMP, 16'd1, 0, 0, 0));
    queue_word(mk(CMD_SNAP_EN, 0, KIND_ANY, 0, SRC_TEMP, 0, 0, 0, 0));
    queue_word(mk(CMD_ADD, 16'h8000, KIND_ROM, 16'h0001, SRC_SNAP, 0, 0, 0, 0));
    queue_word(mk(CMD_CLR_ID, 0, KIND_ANY, 0, SRC_TEMP, 16'hFFFF, 1, 0, 0));
    queue_word(mk(CMD_CLR_SRC, 0, KIND_ANY, 0, SRC_TEMP, 0, 0, 0, 0));
    queue_word(mk(CMD_RSVD_A, 16'hFFFF, KIND_SPARE, 16'hFFFF, SRC_OTHER_B, 16'hFFFF, 1,
                  16'hFFFF, 16'hFFFF));
    queue_word(mk(CMD_RSVD_B, 16'h8000, KIND_ANY, 0, SRC_SNAP, 16'd2, 0, 0, 0));
    // Add-heavy, mixed and clear-heavy stretches take the table from empty to full.
    for (int n = 0; n < RANDOM_WORDS; n++) random_word((n / 60) % 3);

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    while (pend_q.size() != 0 || in_valid || result_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (errors == 0 && result_q.size() == 0) begin
      $display("breakpoint_match_table_core_tb: PASS");
    end else begin
      $display("breakpoint_match_table_core_tb: FAIL");
    end
    $finish;
  end

endmodule
